/* rtl/small_set_table_assert.svh */
// Assertion macros used by the small set table RTL.
`ifndef SMALL_SET_TABLE_ASSERT_SVH
`define SMALL_SET_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sst_pkg.sv */
// Shared types and constants of the small set table.
package sst_pkg;

  localparam int SET_CAPACITY_DEF = 16;
  localparam int DATA_W           = 32;
  localparam int COUNT_W          = 5;

  localparam logic [1:0] MODE_CHECK  = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic compare;
    logic add_go;
    logic del_go;
  } sst_cmd_t;

endpackage

/* rtl/sst_cell.sv */
// One storage cell of the set table: an entry, its match flag and the delete shift link.
module sst_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sst_pkg::sst_cmd_t                 cmd_i,
  input  logic signed [sst_pkg::DATA_W-1:0] value_i,
  input  logic [CNT_W-1:0]                  count_i,
  input  logic signed [sst_pkg::DATA_W-1:0] next_entry_i,
  input  logic                              shift_i,
  output logic                              shift_o,
  output logic                              hit_o,
  output logic signed [sst_pkg::DATA_W-1:0] entry_o
);

  logic signed [sst_pkg::DATA_W-1:0] entry_q;
  logic                              hit_q;
  logic                              live;

  assign live    = CNT_W'(IDX) < count_i;
  // A hit here or in any earlier cell makes this cell take over the next cell's entry on a delete.
  assign shift_o = shift_i | hit_q;
  assign hit_o   = hit_q;
  assign entry_o = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.compare) begin
      hit_q <= live && (entry_q == value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_go && (CNT_W'(IDX) == count_i)) begin
      entry_q <= value_i;
    end else if (cmd_i.del_go && shift_o) begin
      entry_q <= next_entry_i;
    end
  end

endmodule

/* rtl/small_set_table.sv */
// Small set table: up to SET_CAPACITY distinct values held in a row of compare cells.
// An item accepted at one clock edge is compared in all cells in the next cycle and
// applied in the cycle after; done_o is registered from the update state.
// A new item can be accepted in the update state of the last one; only compare holds busy_o.
// Reset clears the entry count; entry contents are undefined until written.
// done_o is a one-cycle strobe and the receiver cannot stall it.
`include "small_set_table_assert.svh"

module small_set_table #(
  parameter int SET_CAPACITY = sst_pkg::SET_CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         mode_i,
  input  logic signed [sst_pkg::DATA_W-1:0]  value_i,
  output logic                               done_o,
  output logic                               found_o,
  output logic [1:0]                         status_o,
  output logic [sst_pkg::COUNT_W-1:0]        count_o
);

  localparam int CNT_W = $clog2(SET_CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e                            state_q, state_d;
  logic [1:0]                        mode_q;
  logic signed [sst_pkg::DATA_W-1:0] value_q;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic                              done_q, found_q;
  logic [1:0]                        status_q, status_d;

  sst_pkg::sst_cmd_t                 cmd;
  logic [SET_CAPACITY-1:0]           hits;
  logic [SET_CAPACITY:0]             shift;
  logic signed [sst_pkg::DATA_W-1:0] entries [SET_CAPACITY];
  logic                              found;
  logic                              full;
  logic                              accept;

  assign accept = start_i && !busy_o;
  assign found  = |hits;
  assign full   = count_q == CNT_W'(SET_CAPACITY);

  assign cmd.compare = state_q == S_CMP;
  assign cmd.add_go  = (state_q == S_UPD) && (mode_q == sst_pkg::MODE_ADD) && !full && !found;
  assign cmd.del_go  = (state_q == S_UPD) && (mode_q == sst_pkg::MODE_DELETE) && found;

  always_comb begin
    status_d = sst_pkg::ST_DONE;
    count_d  = count_q;
    case (mode_q)
      sst_pkg::MODE_ADD: begin
        if (full) begin
          status_d = sst_pkg::ST_FULL;
        end else if (found) begin
          status_d = sst_pkg::ST_PRESENT;
        end else begin
          count_d = CNT_W'(count_q + 1'b1);
        end
      end
      sst_pkg::MODE_DELETE: begin
        if (!found) begin
          status_d = sst_pkg::ST_ABSENT;
        end else begin
          count_d = CNT_W'(count_q - 1'b1);
        end
      end
      default: begin
        status_d = sst_pkg::ST_DONE;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD:   state_d = accept ? S_CMP : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= sst_pkg::MODE_CHECK;
      value_q  <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      status_q <= sst_pkg::ST_DONE;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == S_UPD;
      if (accept) begin
        mode_q  <= mode_i;
        value_q <= value_i;
      end
      if (state_q == S_UPD) begin
        count_q  <= count_d;
        found_q  <= found;
        status_q <= status_d;
      end
    end
  end

  assign shift[0] = 1'b0;

  for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
    logic signed [sst_pkg::DATA_W-1:0] next_entry;

    if (i == SET_CAPACITY - 1) begin : g_last
      assign next_entry = entries[i];
    end else begin : g_mid
      assign next_entry = entries[i+1];
    end

    sst_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .value_i      (value_q),
      .count_i      (count_q),
      .next_entry_i (next_entry),
      .shift_i      (shift[i]),
      .shift_o      (shift[i+1]),
      .hit_o        (hits[i]),
      .entry_o      (entries[i])
    );
  end

  assign busy_o   = state_q == S_CMP;
  assign done_o   = done_q;
  assign found_o  = found_q;
  assign status_o = status_q;
  assign count_o  = sst_pkg::COUNT_W'(count_q);

  `SST_ASSERT_SAME(a_count_in_range, 1'b1, count_q <= CNT_W'(SET_CAPACITY), "count exceeds capacity")
  `SST_ASSERT_SAME(a_hits_unique, state_q == S_UPD, $onehot0(hits), "value matched in more than one cell")
  `SST_ASSERT_NEXT(a_done_after_update, state_q == S_UPD, done_o, "result strobe missing after update")
  `SST_ASSERT_NEXT(a_add_grows, cmd.add_go, count_q == CNT_W'($past(count_q) + 1'b1), "add did not grow count")
  `SST_ASSERT_NEXT(a_accept_busy, accept, busy_o, "accepted item did not start compare")

endmodule
